// ===== src/swrb_pkg.sv =====
// Package for the sequence-window ring buffer: operation and status codes,
// field widths and the controller state type. No dependencies.
package swrb_pkg;

  // Field widths of the channels.
  localparam int LEN_W     = 13;
  localparam int SEQ_W     = 32;
  localparam int DATA_W    = 8;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 8;

  // Default size of the byte store.
  localparam int DEF_STORE_BYTES = 4096;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_BEGIN_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_OPEN_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_BYTE   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_WIN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_OPEN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 8'd1;

  // Register values after reset.
  localparam logic [LEN_W-1:0] RST_RING_BYTES = 13'd4096;
  localparam logic [LEN_W-1:0] RST_SLOT_BYTES = 13'd1024;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HMOD,
    S_EVICT,
    S_WFIN,
    S_MUL,
    S_RMOD,
    S_RBYTE,
    S_DONE
  } state_t;

endpackage

// ===== src/swrb_if.sv =====
// Channel interfaces of the sequence-window ring buffer: input beats,
// result beats and configuration writes. Depends on swrb_pkg.

interface swrb_in_if;
  logic                        valid;
  logic                        ready;
  logic [swrb_pkg::OP_W-1:0]   operation;
  logic [swrb_pkg::DATA_W-1:0] data_in;
  logic [swrb_pkg::LEN_W-1:0]  packet_length;
  logic [swrb_pkg::SEQ_W-1:0]  seq_number;
  logic [swrb_pkg::LEN_W-1:0]  read_limit;

  modport source (output valid, operation, data_in, packet_length, seq_number, read_limit,
                  input ready);
  modport sink (input valid, operation, data_in, packet_length, seq_number, read_limit,
                output ready);
endinterface

interface swrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [swrb_pkg::STAT_W-1:0] status;
  logic [swrb_pkg::LEN_W-1:0]  read_length;
  logic [swrb_pkg::DATA_W-1:0] data_out;
  logic                        last_byte;

  modport source (output valid, status, read_length, data_out, last_byte, input ready);
  modport sink (input valid, status, read_length, data_out, last_byte, output ready);
endinterface

interface swrb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swrb_pkg::CFG_IDX_W-1:0] index;
  logic [swrb_pkg::LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/swrb_ram.sv =====
// Byte store of the ring buffer: one write port and one read port with
// registered read data. No dependencies.
module swrb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/swrb_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle. Used for slot phase
// and ring position. No dependencies.
module swrb_rem #(
  parameter int DW = 45,
  parameter int SW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [SW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [SW-1:0] div;
  logic [CW-1:0] cnt;
  logic          run;
  logic [SW:0]   trial;

  // Shift in the next dividend bit and subtract when it fits.
  assign trial = {rem, dvd[DW-1]};
  assign done  = run && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= CW'(DW);
      dvd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (run && cnt != '0) begin
      cnt <= cnt - 1'b1;
      dvd <= dvd << 1;
      if (trial >= {1'b0, div}) begin
        rem <= SW'(trial - {1'b0, div});
      end else begin
        rem <= SW'(trial);
      end
    end
  end

endmodule

// ===== src/seq_window_ring_buffer_unit.sv =====
// Top level of the sequence-window ring buffer: controller, window state and
// byte store. Depends on swrb_pkg, swrb_if, swrb_ram and swrb_rem.

// A user sends one operation per input beat and receives exactly one result
// beat for it. Write-byte goes straight to the result, and read-byte passes
// through S_RBYTE for the byte store's registered read port. A begin-write
// that fits goes through S_WFIN. When room is lacking and the ring holds
// bytes, it first waits in S_HMOD for the remainder unit to give the head's
// slot phase, then evicts one chunk per cycle in S_EVICT before S_WFIN. An
// open-read in the window goes through S_MUL and S_RMOD, where the bit-serial
// remainder places the slot in the ring. A stalled result beat holds S_DONE.
// The store comes out of reset with undefined contents and needs no clearing
// pass; a write to either size register empties the ring and moves the window
// start to its end.
module seq_window_ring_buffer_unit #(
  parameter int STORE_BYTES = swrb_pkg::DEF_STORE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  swrb_in_if.sink    in_ch,
  swrb_out_if.source out_ch,
  swrb_cfg_if.sink   cfg_ch
);
  import swrb_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int SW = AW + 1;
  localparam int LW = ((SW > LEN_W) ? SW : LEN_W) + 1;
  localparam int BW = SEQ_W + SW;

  state_t state, state_next;

  logic [LEN_W-1:0]  ring_cfg, slot_cfg;
  logic [SW-1:0]     ring, slot;
  logic [AW-1:0]     head, tail, read_pointer;
  logic [SW-1:0]     held;
  logic [SEQ_W-1:0]  window_start, window_end;
  logic [LEN_W-1:0]  write_left, read_left;
  logic [LEN_W-1:0]  to_free, plen_r, limit_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              lead_chunk;
  logic [BW-1:0]     base;

  logic [STAT_W-1:0] res_status;
  logic [LEN_W-1:0]  res_len;
  logic [DATA_W-1:0] res_data;
  logic              res_last;

  logic              rem_start, rem_done;
  logic [BW-1:0]     rem_dividend;
  logic [SW-1:0]     rem_divisor, rem_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_rdata;

  logic              cfg_hit;
  logic              accept;
  logic              need_evict, in_win, fits, out_free;
  logic [SEQ_W-1:0]  offset;
  logic [LW-1:0]     held_plus, waddr_sum, tail_sum;
  logic [LEN_W-1:0]  back;
  logic [SW-1:0]     chunk_raw, chunk;
  logic [SW:0]       head_sum, rp_sum;
  logic [AW-1:0]     head_new, rp_new, rp_inc;
  logic [LEN_W-1:0]  rd_len;
  logic [SW-1:0]     in_last;

  // Saturate the size registers to 1..STORE_BYTES.
  always_comb begin
    if (ring_cfg == '0) begin
      ring = SW'(1);
    end else if (32'(ring_cfg) > 32'(STORE_BYTES)) begin
      ring = SW'(STORE_BYTES);
    end else begin
      ring = SW'(ring_cfg);
    end
    if (slot_cfg == '0) begin
      slot = SW'(1);
    end else if (32'(slot_cfg) > 32'(STORE_BYTES)) begin
      slot = SW'(STORE_BYTES);
    end else begin
      slot = SW'(slot_cfg);
    end
  end

  assign accept     = in_ch.valid && in_ch.ready;
  assign cfg_hit    = cfg_ch.valid && cfg_ch.ready &&
                      (cfg_ch.index == CFG_RING_BYTES || cfg_ch.index == CFG_SLOT_BYTES);
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign held_plus  = LW'(held) + LW'(in_ch.packet_length);
  assign need_evict = held_plus > LW'(ring);
  assign offset     = in_ch.seq_number - window_start;
  assign in_win     = (in_ch.seq_number >= window_start) && (in_ch.seq_number < window_end);
  assign fits       = (LW'(held) + LW'(plen_r)) <= LW'(ring);

  // Write address: tail minus the bytes still to come, modulo the ring.
  always_comb begin
    back      = (LW'(write_left) == LW'(ring)) ? '0 : write_left;
    waddr_sum = LW'(tail) + LW'(ring) - LW'(back);
    if (waddr_sum >= LW'(ring)) begin
      waddr_sum = waddr_sum - LW'(ring);
    end
    mem_waddr = AW'(waddr_sum);
  end

  // Tail after a reservation that fits.
  always_comb begin
    tail_sum = LW'(tail) + LW'(plen_r);
    if (tail_sum >= LW'(ring)) begin
      tail_sum = tail_sum - LW'(ring);
    end
  end

  // One eviction chunk: the first one stops at the next slot boundary.
  always_comb begin
    chunk_raw = lead_chunk ? (slot - rem_q) : slot;
    chunk     = (chunk_raw > held) ? held : chunk_raw;
    head_sum  = (SW+1)'(head) + (SW+1)'(chunk);
    if (head_sum >= (SW+1)'(ring)) begin
      head_new = AW'(head_sum - (SW+1)'(ring));
    end else begin
      head_new = AW'(head_sum);
    end
  end

  // Read length: slot trimmed to the caller's limit and the last packet's bytes.
  always_comb begin
    rd_len  = (LW'(slot) > LW'(limit_r)) ? limit_r : LEN_W'(slot);
    in_last = '0;
    if (seq_r == window_end - 1'b1 &&
        (BW+1)'(held) < ((BW+1)'(base) + (BW+1)'(slot))) begin
      in_last = (base >= BW'(held)) ? '0 : (held - SW'(base));
      if (LW'(in_last) < LW'(rd_len)) begin
        rd_len = LEN_W'(in_last);
      end
    end
  end

  // Slot position and next read position, both modulo the ring.
  always_comb begin
    rp_sum = (SW+1)'(head) + (SW+1)'(rem_q);
    if (rp_sum >= (SW+1)'(ring)) begin
      rp_new = AW'(rp_sum - (SW+1)'(ring));
    end else begin
      rp_new = AW'(rp_sum);
    end
    if ((SW)'(read_pointer) + SW'(1) == ring) begin
      rp_inc = '0;
    end else begin
      rp_inc = read_pointer + 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next   = state;
    in_ch.ready  = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = BW'(head);
    rem_divisor  = slot;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (in_ch.operation)
            OP_BEGIN_WRITE: begin
              if (need_evict && held != '0) begin
                rem_start  = 1'b1;
                state_next = S_HMOD;
              end else begin
                state_next = S_WFIN;
              end
            end
            OP_WRITE_BYTE: begin
              mem_we     = (write_left != '0);
              state_next = S_DONE;
            end
            OP_OPEN_READ: begin
              state_next = in_win ? S_MUL : S_DONE;
            end
            default: begin
              if (read_left != '0) begin
                mem_re     = 1'b1;
                state_next = S_RBYTE;
              end else begin
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_HMOD: begin
        if (rem_done) begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (to_free == '0 || held == '0) begin
          state_next = S_WFIN;
        end
      end
      S_WFIN: begin
        state_next = S_DONE;
      end
      S_MUL: begin
        rem_start    = 1'b1;
        rem_dividend = base;
        rem_divisor  = ring;
        state_next   = S_RMOD;
      end
      S_RMOD: begin
        if (rem_done) begin
          state_next = S_DONE;
        end
      end
      S_RBYTE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Window, ring and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_cfg     <= RST_RING_BYTES;
      slot_cfg     <= RST_SLOT_BYTES;
      head         <= '0;
      tail         <= '0;
      held         <= '0;
      window_start <= '0;
      window_end   <= '0;
      write_left   <= '0;
      read_pointer <= '0;
      read_left    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.operation)
              OP_WRITE_BYTE: begin
                if (write_left != '0) begin
                  write_left <= write_left - 1'b1;
                end
              end
              OP_OPEN_READ: begin
                if (!in_win) begin
                  read_left <= '0;
                end
              end
              OP_READ_BYTE: begin
                if (read_left != '0) begin
                  read_pointer <= rp_inc;
                  read_left    <= read_left - 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EVICT: begin
          if (to_free != '0 && held != '0) begin
            head         <= head_new;
            held         <= held - chunk;
            window_start <= window_start + 1'b1;
          end
        end
        S_WFIN: begin
          if (fits) begin
            tail       <= AW'(tail_sum);
            held       <= held + SW'(plen_r);
            write_left <= plen_r;
            if (seq_r >= window_end) begin
              window_end <= seq_r + 1'b1;
            end
          end
        end
        S_MUL: begin
          read_left <= rd_len;
        end
        S_RMOD: begin
          if (rem_done) begin
            read_pointer <= rp_new;
          end
        end
        default: begin
        end
      endcase

      // A write to either size register empties the ring.
      if (cfg_hit) begin
        if (cfg_ch.index == CFG_RING_BYTES) begin
          ring_cfg <= cfg_ch.data;
        end else begin
          slot_cfg <= cfg_ch.data;
        end
        head         <= '0;
        tail         <= '0;
        held         <= '0;
        write_left   <= '0;
        read_pointer <= '0;
        read_left    <= '0;
        window_start <= window_end;
      end
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Operation scratch registers and the pending result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          plen_r      <= in_ch.packet_length;
          to_free     <= in_ch.packet_length;
          seq_r       <= in_ch.seq_number;
          limit_r     <= in_ch.read_limit;
          lead_chunk  <= 1'b1;
          base        <= BW'(offset) * BW'(slot);
          res_status  <= ST_OK;
          res_len     <= '0;
          res_data    <= '0;
          res_last    <= 1'b0;
          case (in_ch.operation)
            OP_WRITE_BYTE: begin
              if (write_left == '0) begin
                res_status <= ST_NO_OPEN;
              end
            end
            OP_OPEN_READ: begin
              if (!in_win) begin
                res_status <= ST_NO_WIN;
              end
            end
            OP_READ_BYTE: begin
              if (read_left == '0) begin
                res_status <= ST_NO_OPEN;
              end else begin
                res_last <= (read_left == LEN_W'(1));
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EVICT: begin
        if (to_free != '0 && held != '0) begin
          lead_chunk <= 1'b0;
          if (LW'(to_free) > LW'(chunk)) begin
            to_free <= to_free - LEN_W'(chunk);
          end else begin
            to_free <= '0;
          end
        end
      end
      S_WFIN: begin
        if (!fits) begin
          res_status <= ST_NO_ROOM;
        end
      end
      S_MUL: begin
        res_len <= rd_len;
      end
      S_RBYTE: begin
        res_data <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.status      <= res_status;
      out_ch.read_length <= res_len;
      out_ch.data_out    <= res_data;
      out_ch.last_byte   <= res_last;
    end
  end

  swrb_rem #(
    .DW (BW),
    .SW (SW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem_q)
  );

  swrb_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.data_in),
    .re    (mem_re),
    .raddr (read_pointer),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for seq_window_ring_buffer_unit: directed table plus
// random packet traffic, each result beat checked against a typed row or a behavioral model.
// Depends on swrb_pkg, swrb_if and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swrb_pkg::*;

  localparam int MEM_BYTES = DEF_STORE_BYTES;
  localparam int N_ITEMS   = 700;
  localparam int CALM_TAIL = 120;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam int N_DIR     = 19;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [LEN_W-1:0]  rl;
    logic [DATA_W-1:0] dout;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] din;
    logic [LEN_W-1:0]  plen;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  lim;
    logic              chk;
    res_t              res;
  } row_t;

  // Directed rows; typed results only where they are obvious.
  localparam row_t DIR_TAB [0:N_DIR-1] = '{
    '{OP_READ_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_NO_OPEN, 13'd0, 8'h00, 1'b0}},
    '{OP_WRITE_BYTE, 8'h5A, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_NO_OPEN, 13'd0, 8'h00, 1'b0}},
    '{OP_OPEN_READ, 8'h00, 13'd0, 32'd0, 13'd4096, 1'b1, '{ST_NO_WIN, 13'd0, 8'h00, 1'b0}},
    '{OP_BEGIN_WRITE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_OPEN_READ, 8'h00, 13'd0, 32'd0, 13'd4096, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_READ_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_NO_OPEN, 13'd0, 8'h00, 1'b0}},
    '{OP_BEGIN_WRITE, 8'h00, 13'd4096, 32'd1, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_WRITE_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_WRITE_BYTE, 8'hFF, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_WRITE_BYTE, 8'hA5, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_OPEN_READ, 8'h00, 13'd0, 32'd0, 13'd3, 1'b1, '{ST_OK, 13'd3, 8'h00, 1'b0}},
    '{OP_READ_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_READ_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'hFF, 1'b0}},
    '{OP_READ_BYTE, 8'h00, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'hA5, 1'b1}},
    '{OP_BEGIN_WRITE, 8'h00, 13'd1, 32'hFFFFFFFF, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_OPEN_READ, 8'h00, 13'd0, 32'd1, 13'd4096, 1'b1, '{ST_NO_WIN, 13'd0, 8'h00, 1'b0}},
    '{OP_WRITE_BYTE, 8'h3C, 13'd0, 32'd0, 13'd0, 1'b1, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_BEGIN_WRITE, 8'h00, 13'd4096, 32'h12345678, 13'd0, 1'b0, '{ST_OK, 13'd0, 8'h00, 1'b0}},
    '{OP_OPEN_READ, 8'h00, 13'd0, 32'h12345678, 13'd0, 1'b0, '{ST_OK, 13'd0, 8'h00, 1'b0}}
  };

  logic clk;
  logic rst;

  swrb_in_if  in_ch();
  swrb_out_if out_ch();
  swrb_cfg_if cfg_ch();

  seq_window_ring_buffer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model state of the ring and window.
  logic [DATA_W-1:0] ring_mem [MEM_BYTES];
  bit                was_written [MEM_BYTES];
  int unsigned       head_m, tail_m, held_m, wleft_m, rptr_m, rleft_m;
  logic [SEQ_W-1:0]  win_lo, win_hi;
  logic [LEN_W-1:0]  ring_reg, slot_reg;

  res_t   pending_q [$];
  int     err_cnt;
  int     item_cnt;
  int     beat_cnt;
  int     cfg_cnt;
  longint cycle_cnt;
  bit     idle_on;

  function automatic int unsigned sat_size(logic [LEN_W-1:0] v);
    if (v < 1) return 1;
    if (v > MEM_BYTES) return MEM_BYTES;
    return v;
  endfunction

  // Apply a register write to the model: it empties the ring.
  task automatic model_config(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    if (idx == CFG_RING_BYTES) ring_reg = val;
    else if (idx == CFG_SLOT_BYTES) slot_reg = val;
    else return;
    head_m = 0; tail_m = 0; held_m = 0; wleft_m = 0; rptr_m = 0; rleft_m = 0;
    win_lo = win_hi;
  endtask

  // Compute the result of one operation and advance the model.
  task automatic ring_predict(input row_t it, output res_t r);
    int unsigned ring, slot, to_free, chunks, c, back, addr, len, in_last;
    longint unsigned base;
    logic [SEQ_W-1:0] offset;
    ring = sat_size(ring_reg);
    slot = sat_size(slot_reg);
    r = '0;
    head_m %= ring; tail_m %= ring; rptr_m %= ring;
    if (held_m > ring) held_m = ring;
    case (it.op)
      OP_BEGIN_WRITE: begin
        if (held_m + it.plen > ring) begin
          to_free = it.plen;
          chunks = 0;
          while (to_free > 0 && held_m > 0) begin
            c = (chunks == 0) ? slot - (head_m % slot) : slot;
            if (c > held_m) c = held_m;
            head_m = (head_m + c) % ring;
            held_m -= c;
            to_free -= (to_free > c) ? c : to_free;
            chunks++;
          end
          win_lo = win_lo + chunks;
        end
        if (held_m + it.plen > ring) begin
          r.st = ST_NO_ROOM;
        end else begin
          tail_m = (tail_m + it.plen) % ring;
          held_m += it.plen;
          wleft_m = it.plen;
          if (it.seq >= win_hi) win_hi = it.seq + 32'd1;
        end
      end
      OP_WRITE_BYTE: begin
        if (wleft_m == 0) begin
          r.st = ST_NO_OPEN;
        end else begin
          back = wleft_m % ring;
          addr = (tail_m + ring - back) % ring;
          ring_mem[addr] = it.din;
          was_written[addr] = 1'b1;
          wleft_m--;
        end
      end
      OP_OPEN_READ: begin
        if (it.seq < win_lo || it.seq >= win_hi) begin
          r.st = ST_NO_WIN;
          rleft_m = 0;
        end else begin
          offset = it.seq - win_lo;
          base = longint'(offset) * slot;
          len = slot;
          if (len > it.lim) len = it.lim;
          if (it.seq == win_hi - 32'd1 && longint'(held_m) < base + slot) begin
            in_last = (base >= held_m) ? 0 : held_m - int'(base);
            if (in_last < len) len = in_last;
          end
          rptr_m = (head_m + int'(base % ring)) % ring;
          rleft_m = len;
          r.rl = LEN_W'(len);
        end
      end
      default: begin
        if (rleft_m == 0) begin
          r.st = ST_NO_OPEN;
        end else begin
          r.dout = ring_mem[rptr_m % MEM_BYTES];
          rptr_m = (rptr_m + 1) % ring;
          rleft_m--;
          r.last = (rleft_m == 0);
        end
      end
    endcase
  endtask

  // Send one operation beat; a read of a never-written byte becomes a write.
  task automatic send_op(input row_t it);
    res_t r;
    if (it.op == OP_READ_BYTE && rleft_m != 0 && !was_written[rptr_m % MEM_BYTES]) begin
      it.op = OP_WRITE_BYTE;
      it.chk = 1'b0;
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.operation     <= it.op;
    in_ch.data_in       <= it.din;
    in_ch.packet_length <= it.plen;
    in_ch.seq_number    <= it.seq;
    in_ch.read_limit    <= it.lim;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    ring_predict(it, r);
    pending_q.push_back(it.chk ? it.res : r);
    item_cnt++;
  endtask

  task automatic send_simple(logic [OP_W-1:0] op, logic [DATA_W-1:0] din,
                             logic [LEN_W-1:0] plen, logic [SEQ_W-1:0] seq,
                             logic [LEN_W-1:0] lim);
    row_t it;
    it = '0;
    it.op = op; it.din = din; it.plen = plen; it.seq = seq; it.lim = lim;
    send_op(it);
  endtask

  // Register write, issued only with the unit idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_config(idx, val);
    cfg_cnt++;
  endtask

  // One random episode: mostly a full packet write and read-back.
  task automatic random_episode();
    int unsigned ring, plen, nw, nr, span;
    logic [SEQ_W-1:0] seq;
    ring = sat_size(ring_reg);
    if ($urandom_range(0, 9) < 6) begin
      if ($urandom_range(0, 19) == 0) plen = $urandom_range(0, 4096);
      else plen = $urandom_range(0, (ring < 48) ? ring : 48);
      seq = ($urandom_range(0, 9) == 0) ? $urandom : win_hi;
      send_simple(OP_BEGIN_WRITE, 8'h00, LEN_W'(plen), seq,
                  LEN_W'($urandom_range(0, 4096)));
      nw = (plen < 48) ? plen : 48;
      if ($urandom_range(0, 7) == 0 && nw > 0) nw = $urandom_range(0, nw - 1);
      repeat (nw) send_simple(OP_WRITE_BYTE, DATA_W'($urandom), '0, '0, '0);
      if (win_lo < win_hi) begin
        span = win_hi - win_lo - 1;
        if ($urandom_range(0, 1) == 0) seq = win_hi - 32'd1;
        else seq = win_lo + $urandom_range(0, (span < 8) ? span : 8);
        send_simple(OP_OPEN_READ, 8'h00, '0, seq,
                    LEN_W'(($urandom_range(0, 2) == 0) ? 4096 : $urandom_range(0, 4096)));
        nr = ((rleft_m < 64) ? rleft_m : 64) + $urandom_range(0, 1);
        repeat (nr) send_simple(OP_READ_BYTE, 8'h00, '0, '0, '0);
      end
    end else begin
      send_simple(OP_W'($urandom_range(0, 3)), DATA_W'($urandom),
                  LEN_W'($urandom_range(0, 4096)), $urandom,
                  LEN_W'($urandom_range(0, 4096)));
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result stall pattern.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beat_cnt++;
      if (pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result beat: status=%0d len=%0d data=%0h last=%0d",
                 $time, out_ch.status, out_ch.read_length, out_ch.data_out, out_ch.last_byte);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.status !== e.st || out_ch.read_length !== e.rl ||
            out_ch.data_out !== e.dout || out_ch.last_byte !== e.last) begin
          err_cnt++;
          $display("%0t mismatch: expected status=%0d len=%0d data=%0h last=%0d,",
                   $time, e.st, e.rl, e.dout, e.last);
          $display("    got status=%0d len=%0d data=%0h last=%0d",
                   out_ch.status, out_ch.read_length, out_ch.data_out, out_ch.last_byte);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [CFG_IDX_W-1:0] cfg_idx [14];
    logic [LEN_W-1:0]     cfg_val [14];
    int k;
    cfg_idx = '{CFG_RING_BYTES, CFG_SLOT_BYTES, CFG_SLOT_BYTES, CFG_RING_BYTES,
                CFG_RING_BYTES, CFG_SLOT_BYTES, CFG_RING_BYTES, CFG_SLOT_BYTES,
                CFG_RING_BYTES, CFG_SLOT_BYTES, 8'd5, CFG_RING_BYTES,
                CFG_SLOT_BYTES, CFG_RING_BYTES};
    cfg_val = '{13'd64, 13'd16, 13'd0, 13'd0, 13'd8191, 13'd1, 13'd100, 13'd7,
                13'd37, 13'd8000, 13'd123, 13'd4096, 13'd4096, 13'd300};
    err_cnt = 0; item_cnt = 0; beat_cnt = 0; cfg_cnt = 0; cycle_cnt = 0;
    idle_on = 1'b1;
    foreach (was_written[i]) was_written[i] = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    head_m = 0; tail_m = 0; held_m = 0; wleft_m = 0; rptr_m = 0; rleft_m = 0;
    win_lo = '0; win_hi = '0;
    ring_reg = RST_RING_BYTES;
    slot_reg = RST_SLOT_BYTES;

    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_BEGIN_WRITE;
    in_ch.data_in <= '0;
    in_ch.packet_length <= '0;
    in_ch.seq_number <= '0;
    in_ch.read_limit <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_RING_BYTES;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings.
    for (int i = 0; i < N_DIR; i++) send_op(DIR_TAB[i]);

    // Random part, one phase per group of register settings.
    k = 0;
    while (item_cnt < N_ITEMS) begin
      if (k < 14) begin
        write_reg(cfg_idx[k], cfg_val[k]);
        if (k + 1 < 14 && cfg_idx[k + 1] != CFG_RING_BYTES) begin
          write_reg(cfg_idx[k + 1], cfg_val[k + 1]);
          k += 2;
        end else begin
          k += 1;
        end
      end
      for (int p = 0; p < 40 && item_cnt < N_ITEMS; p++) begin
        idle_on = (item_cnt < N_ITEMS - CALM_TAIL);
        random_episode();
      end
    end
    idle_on = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d operations and %0d register writes; %0d result beats checked.",
             item_cnt, cfg_cnt, beat_cnt);
    $display("Mismatches found: %0d.", err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
